// ----- rtl/core/rect_to_polar_converter_top_assert.svh -----
// ----------------------------------------------------------------------------
// rect_to_polar_converter_top_assert
// assertion macros used by the rtl file of the converter
// ----------------------------------------------------------------------------
`ifndef RECT_TO_POLAR_CONVERTER_TOP_ASSERT_SVH
`define RECT_TO_POLAR_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define R2P_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("r2p: same-cycle check failed");

// next-cycle implication
`define R2P_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("r2p: next-cycle check failed");

`endif

// ----- rtl/core/r2p_pkg.sv -----
// ----------------------------------------------------------------------------
// r2p_pkg
// constants, types and the arctangent lookup of the rectangular-to-polar
// converter
// ----------------------------------------------------------------------------
package r2p_pkg;

   localparam int unsigned CORDIC_STAGES_DEF = 16;
   localparam int unsigned MAX_STAGES        = 24;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned SUM_W   = COORD_W + 1;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned CX_W    = 36;
   localparam int unsigned Z_W     = 32;
   localparam int unsigned MAG_W   = 17;
   localparam int unsigned ANG_W   = 17;
   localparam int unsigned K_W     = 28;
   localparam int unsigned LO_W    = 18;
   localparam int unsigned HI_W    = 17;

   localparam logic [K_W-1:0]        INV_GAIN    = 28'd163008219;
   localparam logic [MAG_W-1:0]      MAG_SAT     = 17'd131071;
   localparam logic [MAG_W-1:0]      MAG_MAX     = 17'd92682;
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = 17'sd16384;
   localparam logic signed [ANG_W-1:0] ANG_THREE_Q = 17'sd49152;
   localparam logic signed [ANG_W-1:0] ANG_MIN     = -17'sd16384;
   localparam logic signed [ANG_W-1:0] ANG_ZERO    = 17'sd0;
   localparam logic signed [Z_W+1:0] HALF_TURN   = 34'sd2147483648;
   localparam logic signed [Z_W+1:0] ANG_ROUND   = 34'sd32768;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic HOFF_SEL = 1'b0;
   localparam logic VOFF_SEL = 1'b1;
   localparam logic [COORD_W-1:0] HOFF_RESET = 16'd2;
   localparam logic [COORD_W-1:0] VOFF_RESET = 16'd6;

   typedef struct packed {
      logic x_pos;
      logic x_neg;
      logic y_pos;
      logic y_neg;
   } quad_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [Z_W-1:0] atan_lut(input int unsigned idx);
      logic [Z_W-1:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/rect_to_polar_converter_top.sv -----
// ----------------------------------------------------------------------------
// rect_to_polar_converter_top
// Rectangular-to-polar converter. Each request carries a signed x,y pair;
// the programmed offsets are added and an unrolled vectoring CORDIC returns
// the rounded magnitude and the angle in 1/65536 turn, from -pi/2 to 3pi/2.
//
// Channels: req_* in, rsp_* out, valid/stall on both. A request is taken at
// a clock edge with req_valid high and req_stall low; a response likewise.
// Registers: horizontal_offset at 0x0, vertical_offset at 0x4 over the APB
// port (low 16 bits used), reset values 2 and 6. Write only while idle.
// Pipeline: input add, one register per CORDIC stage, gain multiply,
// rounding and output register. Each CORDIC stage has its own adder.
// Throughput: one request per cycle while no response is stalled.
// Reset: empties the pipeline and reloads the offsets.
// Stall: while a response is held with rsp_stall high the whole pipeline
// freezes and req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "rect_to_polar_converter_top_assert.svh"

module rect_to_polar_converter_top #(
   parameter int unsigned CORDIC_STAGES = r2p_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [r2p_pkg::COORD_W-1:0]   req_x_coord,
   input  logic signed [r2p_pkg::COORD_W-1:0]   req_y_coord,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [r2p_pkg::MAG_W-1:0]     rsp_magnitude,
   output logic signed [r2p_pkg::ANG_W-1:0]     rsp_angle,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic        [r2p_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [r2p_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [r2p_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import r2p_pkg::*;

   localparam int unsigned NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   logic [COORD_W-1:0] hoff_ff;
   logic [COORD_W-1:0] voff_ff;
   logic               csr_wr;

   logic               advance;

   logic signed [SUM_W-1:0] x_in;
   logic signed [SUM_W-1:0] y_in;
   logic        [SUM_W:0]   xabs_in;
   quad_type                quad_in;

   logic                    valid_ff [0:NS];
   logic signed [CX_W-1:0]  cx_ff    [0:NS];
   logic signed [CX_W-1:0]  cy_ff    [0:NS];
   logic signed [Z_W-1:0]   z_ff     [0:NS];
   quad_type                quad_ff  [0:NS];

   logic                          prod_valid_ff;
   logic        [LO_W+K_W-1:0]    prod_lo_ff;
   logic        [HI_W+K_W-1:0]    prod_hi_ff;
   logic signed [ANG_W-1:0]       ang_ff;
   logic        [CX_W-1:0]        cx_clip;
   logic signed [Z_W+1:0]         z_wide;
   logic signed [Z_W+1:0]         z_round;
   logic signed [ANG_W-1:0]       ang_in;

   logic [63:0]        mag_sum;
   logic [19:0]        mag_full;
   logic [MAG_W-1:0]   mag_in;

   logic                    rsp_valid_ff;
   logic [MAG_W-1:0]        rsp_mag_ff;
   logic signed [ANG_W-1:0] rsp_ang_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         hoff_ff <= HOFF_RESET;
         voff_ff <= VOFF_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            HOFF_SEL: hoff_ff <= pwdata[COORD_W-1:0];
            VOFF_SEL: voff_ff <= pwdata[COORD_W-1:0];
            default:  hoff_ff <= hoff_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         HOFF_SEL: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, hoff_ff};
         VOFF_SEL: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, voff_ff};
         default:  prdata = '0;
      endcase
   end

   // global pipeline enable
   assign advance   = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~advance;

   // offset add and quadrant fold
   always_comb begin
      x_in    = SUM_W'(req_x_coord) + SUM_W'($signed(hoff_ff));
      y_in    = SUM_W'(req_y_coord) + SUM_W'($signed(voff_ff));
      xabs_in = x_in[SUM_W-1] ? (SUM_W+1)'(-(SUM_W+1)'(x_in)) : (SUM_W+1)'(x_in);
      quad_in.x_pos = ~x_in[SUM_W-1] & (x_in != '0);
      quad_in.x_neg = x_in[SUM_W-1];
      quad_in.y_pos = ~y_in[SUM_W-1] & (y_in != '0);
      quad_in.y_neg = y_in[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff[0]   <= {{(CX_W-SUM_W-1-FRAC_W){1'b0}}, xabs_in, {FRAC_W{1'b0}}};
         cy_ff[0]   <= {{(CX_W-SUM_W-FRAC_W){y_in[SUM_W-1]}}, y_in, {FRAC_W{1'b0}}};
         z_ff[0]    <= '0;
         quad_ff[0] <= quad_in;
      end
   end

   // cordic stages
   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic signed [CX_W-1:0] sx;
      logic signed [CX_W-1:0] sy;
      logic signed [CX_W-1:0] cx_in;
      logic signed [CX_W-1:0] cy_in;
      logic signed [Z_W-1:0]  z_in;
      logic signed [Z_W-1:0]  atan_k;

      always_comb begin
         sx     = cx_ff[k] >>> k;
         sy     = cy_ff[k] >>> k;
         atan_k = $signed(atan_lut(k));
         if (~cy_ff[k][CX_W-1]) begin
            cx_in = cx_ff[k] + sy;
            cy_in = cy_ff[k] - sx;
            z_in  = z_ff[k] + atan_k;
         end else begin
            cx_in = cx_ff[k] - sy;
            cy_in = cy_ff[k] + sx;
            z_in  = z_ff[k] - atan_k;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            cx_ff[k+1]   <= cx_in;
            cy_ff[k+1]   <= cy_in;
            z_ff[k+1]    <= z_in;
            quad_ff[k+1] <= quad_ff[k];
         end
      end
   end

   // gain partial products and angle unfold
   always_comb begin
      cx_clip = cx_ff[NS][CX_W-1] ? '0 : cx_ff[NS];
      z_wide  = {{2{z_ff[NS][Z_W-1]}}, z_ff[NS]};
      if (quad_ff[NS].x_neg) begin
         z_round = HALF_TURN - z_wide + ANG_ROUND;
      end else begin
         z_round = z_wide + ANG_ROUND;
      end
      if (quad_ff[NS].x_pos || quad_ff[NS].x_neg) begin
         ang_in = z_round[FRAC_W+ANG_W-1:FRAC_W];
      end else if (quad_ff[NS].y_pos) begin
         ang_in = ANG_QUARTER;
      end else if (quad_ff[NS].y_neg) begin
         ang_in = ANG_THREE_Q;
      end else begin
         ang_in = ANG_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_lo_ff <= cx_clip[LO_W-1:0] * INV_GAIN;
         prod_hi_ff <= cx_clip[LO_W+HI_W-1:LO_W] * INV_GAIN;
         ang_ff     <= ang_in;
      end
   end

   // magnitude rounding and saturation
   always_comb begin
      mag_sum  = {1'b0, prod_hi_ff, {LO_W{1'b0}}}
               + {{(64-LO_W-K_W){1'b0}}, prod_lo_ff}
               + (64'd1 << (FRAC_W + 27));
      mag_full = mag_sum[63:FRAC_W+28];
      mag_in   = (mag_full > {3'b000, MAG_SAT}) ? MAG_SAT : mag_full[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_mag_ff <= mag_in;
         rsp_ang_ff <= ang_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_angle     = rsp_ang_ff;

   `R2P_ASSERT_IMP(a_stall_only_full, clock, reset, req_stall, rsp_valid_ff && rsp_stall)
   `R2P_ASSERT_NXT(a_entry_valid, clock, reset, advance, valid_ff[0] == $past(req_valid))
   `R2P_ASSERT_IMP(a_mag_range, clock, reset, rsp_valid_ff, rsp_mag_ff <= MAG_MAX)
   `R2P_ASSERT_IMP(a_ang_low, clock, reset, rsp_valid_ff, rsp_ang_ff >= ANG_MIN)
   `R2P_ASSERT_IMP(a_ang_high, clock, reset, rsp_valid_ff, rsp_ang_ff <= ANG_THREE_Q)

endmodule

// ----- dv/tb_rect_to_polar_converter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rect_to_polar_converter_top
// Self-checking bench for the rectangular-to-polar converter. Requests are
// driven with random gaps and response stalls, and each one is predicted
// with a bit-exact fixed-point CORDIC model. Every accepted response is
// checked in order against it. The offset registers are reprogrammed
// between phases, covering their extremes, and read back after each write.
// ----------------------------------------------------------------------------

localparam int CORDIC_DEPTH = 16;

class polar_scoreboard;
   typedef struct {
      logic [16:0] mag;
      logic [16:0] ang;
   } polar_type;

   polar_type          expected_q[$];
   logic signed [15:0] h_off;
   logic signed [15:0] v_off;
   longint             atan_step[CORDIC_DEPTH];
   int                 errors;
   int                 requests;
   int                 responses;

   function new();
      h_off = 16'sd2;
      v_off = 16'sd6;
      atan_step = '{536870912, 316933406, 167458907, 85004756,
                    42667331, 21354465, 10679838, 5340245,
                    2670163, 1335087, 667544, 333772,
                    166886, 83443, 41722, 20861};
      errors = 0;
      requests = 0;
      responses = 0;
   endfunction

   task report(string what, longint got, longint want);
      $display("error: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function void note_request(logic signed [15:0] x, logic signed [15:0] y);
      longint px, py, cx, cy, z, tx, ty, mag, ang;
      polar_type res;
      px = longint'(x) + longint'(h_off);
      py = longint'(y) + longint'(v_off);
      cx = (px < 0 ? -px : px) * 65536;
      cy = py * 65536;
      z = 0;
      for (int i = 0; i < CORDIC_DEPTH; i++) begin
         tx = cx >>> i;
         ty = cy >>> i;
         if (cy >= 0) begin
            cx = cx + ty;
            cy = cy - tx;
            z = z + atan_step[i];
         end else begin
            cx = cx - ty;
            cy = cy + tx;
            z = z - atan_step[i];
         end
      end
      if (cx < 0) cx = 0;
      mag = (cx * 64'sd163008219 + (64'sd1 <<< 43)) >>> 44;
      if (mag > 131071) mag = 131071;
      if (px > 0) begin
         ang = (z + 32768) >>> 16;
      end else if (px < 0) begin
         ang = (64'sd2147483648 - z + 32768) >>> 16;
      end else if (py > 0) begin
         ang = 16384;
      end else if (py < 0) begin
         ang = 49152;
      end else begin
         ang = 0;
      end
      res.mag = mag[16:0];
      res.ang = ang[16:0];
      expected_q.push_back(res);
      requests++;
   endfunction

   task check_response(logic [16:0] mag, logic signed [16:0] ang);
      polar_type want;
      responses++;
      if (expected_q.size() == 0) begin
         report("response with nothing pending, magnitude", mag, 0);
         return;
      end
      want = expected_q.pop_front();
      if (mag !== want.mag) report("magnitude", mag, want.mag);
      if (ang !== want.ang) report("angle", ang, $signed(want.ang));
   endtask

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_rect_to_polar_converter_top;

   typedef enum logic [2:0] {
      HOFF_ADDR = 3'h0,
      VOFF_ADDR = 3'h4
   } csr_addr_type;

   localparam int LATENCY    = CORDIC_DEPTH + 3;
   localparam int IDLE_PCT   = 24;
   localparam int PHASE_LEN  = 130;
   localparam int WDOG_LIMIT = 5000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_x_coord;
   logic signed [15:0] req_y_coord;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [16:0]        rsp_magnitude;
   logic signed [16:0] rsp_angle;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   polar_scoreboard sb;
   bit              req_throttle;
   bit              rsp_throttle;
   int              idle_count;
   int              settings_run;

   rect_to_polar_converter_top #(
      .CORDIC_STAGES(CORDIC_DEPTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle     (rsp_angle),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= rsp_throttle && ($urandom_range(99) < IDLE_PCT);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_x_coord, req_y_coord);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_magnitude, rsp_angle);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_count <= 0;
         end else if (idle_count >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d responses pending", sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   task automatic send_request(input logic signed [15:0] x, input logic signed [15:0] y);
      if (req_throttle) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic csr_write(input csr_addr_type addr, input logic signed [15:0] value);
      logic [31:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      if (addr == HOFF_ADDR) sb.h_off = value;
      else sb.v_off = value;
      // read back
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd[15:0] !== value) sb.report("register readback", $signed(rd[15:0]), value);
   endtask

   task automatic set_offsets(input logic signed [15:0] h, input logic signed [15:0] v);
      drain();
      csr_write(HOFF_ADDR, h);
      csr_write(VOFF_ADDR, v);
      settings_run++;
   endtask

   // coordinate that lands the shifted value on target, else a random one
   function automatic logic signed [15:0] aim(input int target, input logic signed [15:0] off);
      int v;
      v = target - int'(off);
      if (v < -32768 || v > 32767) return 16'($urandom);
      return 16'(v);
   endfunction

   function automatic logic signed [15:0] corner();
      case ($urandom_range(3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   task automatic random_requests(input int count);
      logic signed [15:0] x, y;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            6: begin
               x = aim($urandom_range(4) - 2, sb.h_off);
               y = 16'($urandom);
            end
            7: begin
               x = aim($urandom_range(64) - 32, sb.h_off);
               y = aim($urandom_range(64) - 32, sb.v_off);
            end
            8: begin
               x = corner();
               y = corner();
            end
            9: begin
               x = 16'($urandom);
               y = aim($urandom_range(4) - 2, sb.v_off);
            end
            default: begin
               x = 16'($urandom);
               y = 16'($urandom);
            end
         endcase
         send_request(x, y);
      end
   endtask

   initial begin
      sb = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_x_coord  = '0;
      req_y_coord  = '0;
      rsp_stall    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;
      idle_count   = 0;
      settings_run = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset offsets: origin, both axes, corners
      send_request(-16'sd2, -16'sd6);
      send_request(-16'sd2, 16'sd100);
      send_request(-16'sd2, -16'sd100);
      send_request(-16'sd3, -16'sd6);
      send_request(16'sd5, -16'sd6);
      send_request(16'sh7fff, 16'sh7fff);
      send_request(16'sh8000, 16'sh8000);
      send_request(16'sh7fff, 16'sh8000);
      send_request(16'sh8000, 16'sh7fff);
      send_request(16'sd0, 16'sd0);

      // largest magnitude, angle edges near three quarters of a turn
      set_offsets(16'sh8000, 16'sh8000);
      send_request(16'sh8000, 16'sh8000);
      send_request(16'sh7fff, 16'sh8000);
      send_request(16'sh7fff, 16'sh7fff);
      send_request(16'sh0000, 16'sh7fff);

      // angle edge near minus a quarter turn, y axis at full reach
      set_offsets(16'sh7fff, 16'sh8000);
      send_request(-16'sd32766, 16'sh8000);
      send_request(-16'sd32767, 16'sh8000);
      send_request(-16'sd32767, 16'sh7fff);
      send_request(16'sh7fff, 16'sh8000);

      random_requests(PHASE_LEN);
      set_offsets(16'sd0, 16'sd0);
      random_requests(PHASE_LEN);
      set_offsets(16'sh7fff, 16'sh7fff);
      random_requests(PHASE_LEN);

      // no idling on either side
      set_offsets(16'sh8000, 16'sh7fff);
      req_throttle = 1'b0;
      rsp_throttle = 1'b0;
      random_requests(PHASE_LEN);
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;

      set_offsets(16'sh8000, 16'sh8000);
      random_requests(PHASE_LEN);
      set_offsets(16'($urandom), 16'($urandom));
      random_requests(PHASE_LEN);

      drain();
      repeat (LATENCY + 4) @(negedge clock);
      $display("checked %0d of %0d requests across %0d offset settings",
               sb.responses, sb.requests, settings_run);
      $display("covered origin, both axes, angle rounding edges and full-scale magnitude");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
